/* hdl/fixed_point_alu_macros.svh */
// Assertion macros for the fixed-point ALU checker.
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define FPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define FPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/fpa_pkg.sv */
`timescale 1ns / 1ps
package fpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MIN = 4'd4,
    OP_MAX = 4'd5,
    OP_INC = 4'd6,
    OP_DEC = 4'd7,
    OP_I2F = 4'd8,
    OP_F2I = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    REL_LESS    = 2'd0,
    REL_EQUAL   = 2'd1,
    REL_GREATER = 2'd2
  } rel_t;

  // Per-item control that rides along the pipe.
  typedef struct packed {
    logic [3:0] cmd;
    logic [1:0] relation;
    logic       ovf;
    logic       dz;
    logic       neg;
  } ctl_t;

endpackage

/* hdl/fixed_point_alu.sv */
`timescale 1ns / 1ps
// Signed fixed-point ALU, raw two's-complement values with FRAC_BITS fraction bits.
// Input stream: one item = opcode plus two operands (add, sub, mul, div, min, max,
//   inc, dec, int-to-fixed, fixed-to-int). Output stream: one item per input item,
//   in order: result, relation of a to b, overflow and divide-by-zero flags.
// Pipeline: front stage, a row of DATA_WIDTH + FRAC_BITS restoring divider cells,
//   then the back stage; every opcode passes through every stage, in order.
// Throughput: one item per cycle unless out_tready stalls the pipe. Each divider
//   cell yields one quotient bit.
// Front stage: operand decode, add/sub/inc/dec/min/max/convert, magnitude multiply.
// Back stage: divide rounding and saturation, doubles as the output register.
// Stall: each stage moves when it is empty or the stage after it moves, so
//   bubbles collapse and in_tready stays high while the pipe has any hole,
//   even if out_tready is low. Held results stay stable.
// Reset: all stage valid bits clear, the pipe is empty; no clearing pass.
module fixed_point_alu #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // cmd[3:0], operand_a, operand_b, zero pad
  input  logic [((2*DATA_WIDTH+4+7)/8)*8-1:0]         in_tdata,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  // result, relation[1:0], overflow, divide_by_zero, zero pad
  output logic [((DATA_WIDTH+4+7)/8)*8-1:0]           out_tdata
);
  localparam int W      = DATA_WIDTH;
  localparam int Q      = DATA_WIDTH + FRAC_BITS;
  localparam int NSTG   = Q + 2;
  localparam int OUT_TW = ((DATA_WIDTH + 4 + 7) / 8) * 8;

  // Boundary j: 0 is the front output, j is the output of cell j-1.
  logic          c_v   [Q+1];
  fpa_pkg::ctl_t c_ctl [Q+1];
  logic [W-1:0]  c_res [Q+1];
  logic [Q-1:0]  c_num [Q+1];
  logic [W-1:0]  c_d   [Q+1];
  logic [W-1:0]  c_rem [Q+1];
  logic [Q-1:0]  c_quo [Q+1];

  logic          stg_v  [NSTG];
  logic          stg_en [NSTG];
  fpa_pkg::ctl_t o_ctl;
  logic [W-1:0]  o_res;

  // Stage advance: empty or the next stage advances.
  always_comb begin
    stg_en[NSTG-1] = !stg_v[NSTG-1] || out_tready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      stg_en[i] = !stg_v[i] || stg_en[i+1];
    end
  end

  assign in_tready = stg_en[0];

  fpa_front #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (stg_en[0]),
    .in_valid  (in_tvalid),
    .cmd       (in_tdata[3:0]),
    .operand_a (in_tdata[W+3:4]),
    .operand_b (in_tdata[2*W+3:W+4]),
    .out_valid (c_v[0]),
    .out_ctl   (c_ctl[0]),
    .out_res   (c_res[0]),
    .out_num   (c_num[0]),
    .out_d     (c_d[0])
  );

  assign c_rem[0]  = '0;
  assign c_quo[0]  = '0;
  assign stg_v[0]  = c_v[0];

  for (genvar j = 0; j < Q; j++) begin : g_cell
    fpa_div_cell #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (stg_en[j+1]),
      .in_valid  (c_v[j]),
      .in_ctl    (c_ctl[j]),
      .in_res    (c_res[j]),
      .in_num    (c_num[j]),
      .in_d      (c_d[j]),
      .in_rem    (c_rem[j]),
      .in_quo    (c_quo[j]),
      .out_valid (c_v[j+1]),
      .out_ctl   (c_ctl[j+1]),
      .out_res   (c_res[j+1]),
      .out_num   (c_num[j+1]),
      .out_d     (c_d[j+1]),
      .out_rem   (c_rem[j+1]),
      .out_quo   (c_quo[j+1])
    );
    assign stg_v[j+1] = c_v[j+1];
  end

  fpa_back #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (stg_en[NSTG-1]),
    .in_valid  (c_v[Q]),
    .in_ctl    (c_ctl[Q]),
    .in_res    (c_res[Q]),
    .in_d      (c_d[Q]),
    .in_rem    (c_rem[Q]),
    .in_quo    (c_quo[Q]),
    .out_valid (stg_v[NSTG-1]),
    .out_ctl   (o_ctl),
    .out_res   (o_res)
  );

  // Unused tail of c_num at the last boundary is simply left open.
  assign out_tvalid = stg_v[NSTG-1];
  assign out_tdata  = OUT_TW'({o_ctl.dz, o_ctl.ovf, o_ctl.relation, o_res});

endmodule

/* hdl/fpa_front.sv */
`timescale 1ns / 1ps
module fpa_front #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [3:0]                          cmd,
  input  logic [DATA_WIDTH-1:0]               operand_a,
  input  logic [DATA_WIDTH-1:0]               operand_b,
  output logic                                out_valid,
  output fpa_pkg::ctl_t                       out_ctl,
  output logic [DATA_WIDTH-1:0]               out_res,
  output logic [DATA_WIDTH+FRAC_BITS-1:0]     out_num,
  output logic [DATA_WIDTH-1:0]               out_d
);
  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W + 1;
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] RND  = W'((1 << F) - 1);
  localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

  logic                valid_r;
  fpa_pkg::ctl_t       ctl_r, ctl_nxt;
  logic [W-1:0]        res_r, res_nxt;
  logic [W-1:0]        n_r, d_r, ma, mb;
  logic [2*W-1:0]      prod_r;
  logic [W:0]          sum;
  logic [W-1:0]        op2, f2i_tmp;
  logic                use_sub, a_neg, b_neg, hi_ones, hi_zeros;
  logic [PW-1:0]       msum, mq, mlim;

  assign a_neg = operand_a[W-1];
  assign b_neg = operand_b[W-1];
  assign ma = a_neg ? (~operand_a + W'(1)) : operand_a;
  assign mb = b_neg ? (~operand_b + W'(1)) : operand_b;
  assign use_sub = (cmd == fpa_pkg::OP_SUB) || (cmd == fpa_pkg::OP_DEC);
  assign op2 = ((cmd == fpa_pkg::OP_INC) || (cmd == fpa_pkg::OP_DEC)) ? W'(1) : operand_b;
  assign sum = use_sub ? ({a_neg, operand_a} - {op2[W-1], op2})
                       : ({a_neg, operand_a} + {op2[W-1], op2});
  assign hi_ones  = &operand_a[W-1:W-1-F];
  assign hi_zeros = ~|operand_a[W-1:W-1-F];
  assign f2i_tmp  = operand_a + (a_neg ? RND : '0);

  always_comb begin
    ctl_nxt     = '0;
    ctl_nxt.cmd = cmd;
    ctl_nxt.neg = a_neg ^ b_neg;
    if ($signed(operand_a) < $signed(operand_b)) begin
      ctl_nxt.relation = fpa_pkg::REL_LESS;
    end else if (operand_a == operand_b) begin
      ctl_nxt.relation = fpa_pkg::REL_EQUAL;
    end else begin
      ctl_nxt.relation = fpa_pkg::REL_GREATER;
    end
    res_nxt = '0;
    unique case (cmd)
      fpa_pkg::OP_ADD, fpa_pkg::OP_SUB, fpa_pkg::OP_INC, fpa_pkg::OP_DEC: begin
        if (sum[W] != sum[W-1]) begin
          ctl_nxt.ovf = 1'b1;
          res_nxt     = sum[W] ? MINV : MAXV;
        end else begin
          res_nxt = sum[W-1:0];
        end
      end
      fpa_pkg::OP_DIV: begin
        if (operand_b == '0) begin
          ctl_nxt.dz = 1'b1;
          res_nxt    = a_neg ? MINV : MAXV;
        end
      end
      fpa_pkg::OP_MIN: res_nxt = ($signed(operand_a) <= $signed(operand_b)) ? operand_a : operand_b;
      fpa_pkg::OP_MAX: res_nxt = ($signed(operand_a) >= $signed(operand_b)) ? operand_a : operand_b;
      fpa_pkg::OP_I2F: begin
        if (!hi_ones && !hi_zeros) begin
          ctl_nxt.ovf = 1'b1;
          res_nxt     = a_neg ? MINV : MAXV;
        end else begin
          res_nxt = operand_a << F;
        end
      end
      fpa_pkg::OP_F2I: res_nxt = W'($signed(f2i_tmp) >>> F);
      default:         res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r  <= ctl_nxt;
      res_r  <= res_nxt;
      n_r    <= ma;
      d_r    <= mb;
      prod_r <= ma * mb;
    end
  end

  // Multiply finish: round half away from zero, scale, saturate.
  assign msum = {1'b0, prod_r} + HALF;
  assign mq   = msum >> F;
  assign mlim = ctl_r.neg ? PW'(MINV) : PW'(MAXV);

  always_comb begin
    out_ctl = ctl_r;
    out_res = res_r;
    if (ctl_r.cmd == fpa_pkg::OP_MUL) begin
      if (mq > mlim) begin
        out_ctl.ovf = 1'b1;
        out_res     = ctl_r.neg ? MINV : MAXV;
      end else begin
        out_res = ctl_r.neg ? (~mq[W-1:0] + W'(1)) : mq[W-1:0];
      end
    end
  end

  assign out_valid = valid_r;
  assign out_num   = {n_r, {F{1'b0}}};
  assign out_d     = d_r;

endmodule

/* hdl/fpa_div_cell.sv */
`timescale 1ns / 1ps
module fpa_div_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  fpa_pkg::ctl_t                   in_ctl,
  input  logic [DATA_WIDTH-1:0]           in_res,
  input  logic [DATA_WIDTH+FRAC_BITS-1:0] in_num,
  input  logic [DATA_WIDTH-1:0]           in_d,
  input  logic [DATA_WIDTH-1:0]           in_rem,
  input  logic [DATA_WIDTH+FRAC_BITS-1:0] in_quo,
  output logic                            out_valid,
  output fpa_pkg::ctl_t                   out_ctl,
  output logic [DATA_WIDTH-1:0]           out_res,
  output logic [DATA_WIDTH+FRAC_BITS-1:0] out_num,
  output logic [DATA_WIDTH-1:0]           out_d,
  output logic [DATA_WIDTH-1:0]           out_rem,
  output logic [DATA_WIDTH+FRAC_BITS-1:0] out_quo
);
  localparam int W = DATA_WIDTH;
  localparam int Q = DATA_WIDTH + FRAC_BITS;

  logic          valid_r;
  fpa_pkg::ctl_t ctl_r;
  logic [W-1:0]  res_r, d_r, rem_r, rem_nxt;
  logic [Q-1:0]  num_r, quo_r;
  logic [W:0]    trial, diff;
  logic          ge;

  // One restoring step: bring down the next dividend bit.
  assign trial   = {in_rem, in_num[Q-1]};
  assign diff    = trial - {1'b0, in_d};
  assign ge      = trial >= {1'b0, in_d};
  assign rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r <= in_ctl;
      res_r <= in_res;
      num_r <= in_num << 1;
      d_r   <= in_d;
      rem_r <= rem_nxt;
      quo_r <= {in_quo[Q-2:0], ge};
    end
  end

  assign out_valid = valid_r;
  assign out_ctl   = ctl_r;
  assign out_res   = res_r;
  assign out_num   = num_r;
  assign out_d     = d_r;
  assign out_rem   = rem_r;
  assign out_quo   = quo_r;

endmodule

/* hdl/fpa_back.sv */
`timescale 1ns / 1ps
module fpa_back #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  fpa_pkg::ctl_t                   in_ctl,
  input  logic [DATA_WIDTH-1:0]           in_res,
  input  logic [DATA_WIDTH-1:0]           in_d,
  input  logic [DATA_WIDTH-1:0]           in_rem,
  input  logic [DATA_WIDTH+FRAC_BITS-1:0] in_quo,
  output logic                            out_valid,
  output fpa_pkg::ctl_t                   out_ctl,
  output logic [DATA_WIDTH-1:0]           out_res
);
  localparam int W = DATA_WIDTH;
  localparam int Q = DATA_WIDTH + FRAC_BITS;
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic          valid_r;
  fpa_pkg::ctl_t ctl_r, ctl_nxt;
  logic [W-1:0]  res_r, res_nxt;
  logic          round_up;
  logic [Q:0]    qmag, qlim;

  // Round to nearest: bump when twice the remainder reaches the divisor.
  assign round_up = {in_rem, 1'b0} >= {1'b0, in_d};
  assign qmag     = {1'b0, in_quo} + (Q+1)'(round_up);
  assign qlim     = in_ctl.neg ? (Q+1)'(MINV) : (Q+1)'(MAXV);

  always_comb begin
    ctl_nxt = in_ctl;
    res_nxt = in_res;
    if ((in_ctl.cmd == fpa_pkg::OP_DIV) && !in_ctl.dz) begin
      if (qmag > qlim) begin
        ctl_nxt.ovf = 1'b1;
        res_nxt     = in_ctl.neg ? MINV : MAXV;
      end else begin
        res_nxt = in_ctl.neg ? (~qmag[W-1:0] + W'(1)) : qmag[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r <= ctl_nxt;
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_ctl   = ctl_r;
  assign out_res   = res_r;

endmodule

/* hdl/fpa_checker.sv */
`timescale 1ns / 1ps
`include "fixed_point_alu_macros.svh"
module fpa_checker #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [((2*DATA_WIDTH+4+7)/8)*8-1:0] in_tdata,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [((DATA_WIDTH+4+7)/8)*8-1:0]   out_tdata
);
  localparam int W = DATA_WIDTH;
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0] res;
  logic         ovf, dz, sat;

  assign res = out_tdata[W-1:0];
  assign ovf = out_tdata[W+2];
  assign dz  = out_tdata[W+3];
  assign sat = (res == MAXV) || (res == MINV);

  `FPA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled output item changed")
  `FPA_ASSERT(a_flags_excl, !(out_tvalid && ovf && dz), "overflow and divide by zero together")
  `FPA_ASSERT(a_sat_value, !(out_tvalid && (ovf || dz)) || sat, "flagged item not saturated")
  `FPA_ASSERT(a_rel_code, !out_tvalid || (out_tdata[W+1:W] != 2'd3), "relation code out of range")
  `FPA_ASSERT_NEXT(a_hole_ready, !out_tvalid, in_tready || out_tvalid, "pipe hole but input held off")

endmodule

bind fixed_point_alu fpa_checker #(
  .DATA_WIDTH(DATA_WIDTH),
  .FRAC_BITS (FRAC_BITS)
) u_fpa_checker (.*);

/* test/tb_fixed_point_alu.sv */
`timescale 1ns / 1ps
module tb_fixed_point_alu;

  localparam int DW = 32;
  localparam int FB = 8;
  localparam int IN_W = ((2*DW+4+7)/8)*8;
  localparam int OUT_W = ((DW+4+7)/8)*8;
  localparam int PIPE_LAT = DW + FB + 2;
  localparam longint MAX_CYCLES = 400000;
  localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S_MIN = 32'sh80000000;

  // Packed from the lowest bit up: result, relation, overflow, divide_by_zero.
  typedef struct packed {
    logic        dz;
    logic        overflow;
    logic [1:0]  relation;
    logic [31:0] result;
  } alu_res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;  // cmd[3:0], operand_a, operand_b, zero pad
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_W-1:0] out_tdata;     // result, relation[1:0], overflow, divide_by_zero, pad

  alu_res_t results_due[$];
  int errors = 0;
  longint cycle = 0;
  bit hold_off = 0;  // long receiver stall request
  int rx_wait = 0;   // receiver idle cycles left before the next item

  fixed_point_alu #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Saturate a wide signed value to 32 bits.
  function automatic logic [31:0] clamp(input logic signed [127:0] v, output logic ovf);
    ovf = 0;
    if (v > 128'(S_MAX)) begin
      ovf = 1;
      return S_MAX;
    end
    if (v < 128'(S_MIN) - 128'sd0 && v < -128'sd2147483648) begin
      ovf = 1;
      return S_MIN;
    end
    return v[31:0];
  endfunction

  function automatic alu_res_t alu_predict(logic [3:0] cmd, logic signed [31:0] a,
                                           logic signed [31:0] b);
    alu_res_t r;
    logic signed [127:0] wa, wb, w;
    logic [127:0] ma, mb, q, rem;
    logic ovf;
    logic neg;
    wa = a;
    wb = b;
    r = '0;
    ovf = 0;
    r.relation = (a < b) ? fpa_pkg::REL_LESS
               : ((a == b) ? fpa_pkg::REL_EQUAL : fpa_pkg::REL_GREATER);
    ma = wa < 0 ? -wa : wa;
    mb = wb < 0 ? -wb : wb;
    neg = (a < 0) != (b < 0);
    case (cmd)
      fpa_pkg::OP_ADD: r.result = clamp(wa + wb, ovf);
      fpa_pkg::OP_SUB: r.result = clamp(wa - wb, ovf);
      fpa_pkg::OP_INC: r.result = clamp(wa + 1, ovf);
      fpa_pkg::OP_DEC: r.result = clamp(wa - 1, ovf);
      fpa_pkg::OP_MUL: begin
        q = (ma * mb + (128'd1 << (FB-1))) >> FB;  // round half away from zero
        w = neg ? -$signed(q) : $signed(q);
        r.result = clamp(w, ovf);
      end
      fpa_pkg::OP_DIV: begin
        if (b == 0) begin
          r.dz = 1;
          r.result = (a < 0) ? S_MIN : S_MAX;
        end else begin
          q = (ma << FB) / mb;
          rem = (ma << FB) % mb;
          if (rem >= mb - rem) q = q + 1;
          w = neg ? -$signed(q) : $signed(q);
          r.result = clamp(w, ovf);
        end
      end
      fpa_pkg::OP_MIN: r.result = (a <= b) ? a : b;
      fpa_pkg::OP_MAX: r.result = (a >= b) ? a : b;
      fpa_pkg::OP_I2F: r.result = clamp(wa * (128'sd1 <<< FB), ovf);
      fpa_pkg::OP_F2I: r.result = a / 32'sd256;  // truncation toward zero
      default: r.result = '0;
    endcase
    r.overflow = ovf;
    return r;
  endfunction

  // tvalid stays up between back-to-back items; drain() drops it.
  task automatic send_item(logic [3:0] cmd, logic [31:0] a, logic [31:0] b, bit gaps = 1);
    int gap;
    gap = gaps ? $urandom_range(0, 9) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= IN_W'({b, a, cmd});
    results_due.push_back(alu_predict(cmd, a, b));
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Receiver: per-item random wait, and a long hold-off on request.
  always @(posedge clk) begin
    int w;
    if (!rst_n || hold_off) begin
      out_tready <= 0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_tready <= 0;
    end else if (out_tready && out_tvalid) begin
      w = $urandom_range(0, 9);
      rx_wait <= (w > 0) ? w - 1 : 0;
      out_tready <= (w == 0);
    end else begin
      out_tready <= 1;
    end
  end

  always @(posedge clk) begin
    alu_res_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[DW+3:0];
      if (results_due.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
      end else begin
        exp_r = results_due.pop_front();
        if (got.result !== exp_r.result) begin
          $error("result exp %h got %h", exp_r.result, got.result); errors++;
        end
        if (got.relation !== exp_r.relation) begin
          $error("relation exp %0d got %0d", exp_r.relation, got.relation); errors++;
        end
        if (got.overflow !== exp_r.overflow) begin
          $error("overflow exp %0d got %0d", exp_r.overflow, got.overflow); errors++;
        end
        if (got.dz !== exp_r.dz) begin
          $error("divide_by_zero exp %0d got %0d", exp_r.dz, got.dz); errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? S_MAX : S_MIN;
      1: return 32'($signed($urandom_range(0, 1024)) - 512);
      2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  // Extremes, every operation, zero divisor, rounding ties, unused opcodes.
  task automatic test_directed();
    send_item(fpa_pkg::OP_ADD, S_MAX, 1);
    send_item(fpa_pkg::OP_ADD, S_MIN, S_MIN);
    send_item(fpa_pkg::OP_SUB, S_MIN, 1);
    send_item(fpa_pkg::OP_SUB, S_MAX, S_MIN);
    send_item(fpa_pkg::OP_MUL, S_MAX, S_MAX);
    send_item(fpa_pkg::OP_MUL, S_MIN, S_MAX);
    send_item(fpa_pkg::OP_MUL, 32'h80, 32'h1);      // exact tie, +
    send_item(fpa_pkg::OP_MUL, 32'hffffff80, 32'h1); // exact tie, -
    send_item(fpa_pkg::OP_DIV, 32'd5, 32'd0);
    send_item(fpa_pkg::OP_DIV, S_MIN, 32'd0);
    send_item(fpa_pkg::OP_DIV, S_MIN, 32'hffffffff);
    send_item(fpa_pkg::OP_DIV, 32'd1, 32'd512);       // tie
    send_item(fpa_pkg::OP_MIN, S_MIN, S_MAX);
    send_item(fpa_pkg::OP_MAX, 32'd7, 32'd7);
    send_item(fpa_pkg::OP_INC, S_MAX, 0);
    send_item(fpa_pkg::OP_DEC, S_MIN, 0);
    send_item(fpa_pkg::OP_I2F, 32'h7fffff, 0);
    send_item(fpa_pkg::OP_I2F, 32'h800000, 0);
    send_item(fpa_pkg::OP_I2F, 32'hff800000, 0);
    send_item(fpa_pkg::OP_I2F, 32'hff7fffff, 0);
    send_item(fpa_pkg::OP_F2I, 32'hffffff01, 0);
    send_item(fpa_pkg::OP_F2I, S_MIN, S_MAX);
    send_item(4'd10, 32'd3, 32'd3);
    send_item(4'd15, 32'hffffffff, 32'd0);
  endtask

  task automatic test_random(int n);
    logic [3:0] cmd;
    logic [31:0] b;
    repeat (n) begin
      cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
      b = ($urandom_range(0, 15) == 0) ? 32'd0 : rand_operand();
      send_item(cmd, rand_operand(), b, $urandom_range(0, 3) != 0);
    end
  endtask

  // Receiver stalls long; sender keeps offering until the pipe backs up.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (3 * PIPE_LAT) @(posedge clk);
        hold_off = 0;
      end
      repeat (2 * PIPE_LAT) send_item(4'($urandom_range(0, 9)), $urandom, $urandom, 0);
    join
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    drain();
    test_backpressure();
    test_random(1300);
    drain();
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (errors == 0 && results_due.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
